// File: rtl/tcpm_pkg.sv
// Shared types, sizes and codes of the text command parser and matcher.
package tcpm_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int MAX_ID_LEN  = 16;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int POS_W = $clog2(MAX_ID_LEN);
    localparam int LEN_W = $clog2(MAX_ID_LEN + 1);

    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int ENTRY_W  = 4;
    localparam int CPOS_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CIDX_W   = 4;
    localparam int CVAL_W   = 32;

    localparam logic [REQ_W-1:0] REQ_CMD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NAME   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENABLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Table write request broadcast to every cell.
    typedef struct packed {
        logic                name_we;
        logic                en_we;
        logic [ENTRY_W-1:0]  entry;
        logic [CPOS_W-1:0]   pos;
        logic [BYTE_W-1:0]   data;
        logic                en;
    } t_wr;

    // Parse state seen by the cells and the result stage.
    typedef struct packed {
        logic [MAX_ID_LEN-1:0][BYTE_W-1:0] id;
        logic [LEN_W-1:0]                  len;
        logic                              bad;
        logic [VALUE_BITS-1:0]             value;
    } t_parse;

    // Search token passed from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             bad;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_tok;

endpackage

// File: rtl/tcpm_if.sv
// Valid/ready channel interfaces for request words and result words.
interface tcpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic [3:0] entry_index;
    logic [3:0] char_position;
    logic       enable_value;

    modport source (output valid, req_type, byte_value, entry_index, char_position,
                    enable_value, input ready);
    modport sink (input valid, req_type, byte_value, entry_index, char_position,
                  enable_value, output ready);
endinterface

interface tcpm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  command_index;
    logic [31:0] command_value;

    modport source (output valid, status, command_index, command_value, input ready);
    modport sink (input valid, status, command_index, command_value, output ready);
endinterface

// File: rtl/text_command_parse_and_match.sv
// Top level: request decode, parser, chain of entry cells and result register.
// A non-terminating byte or a table write does not stall the input, and the next word is taken
// in the following cycle.
// A zero byte starts a search token that passes one cell per cycle along NUM_ENTRIES
// cells and waits at the last cell while an untaken result is held; the result word is
// registered as the token leaves, and no word is taken before then.
// Synchronous active-low reset clears all names, enables, parse state and result valid.
module text_command_parse_and_match (
    input  logic i_clk,
    input  logic i_rst_n,
    tcpm_in_if.sink    i_cmd,
    tcpm_out_if.source o_res
);
    import tcpm_pkg::*;

    logic   r_sweep;
    logic   r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [CIDX_W-1:0]   r_index;
    logic [CVAL_W-1:0]   r_value;

    logic   accept;
    logic   cmd_byte;
    logic   launch;
    logic   leave;
    logic   hold;
    t_wr    wr;
    t_parse parse;
    t_tok   tok [NUM_ENTRIES+1];
    t_tok   last;

    assign i_cmd.ready = !r_sweep;
    assign accept      = i_cmd.valid && !r_sweep;
    assign cmd_byte    = accept && (i_cmd.req_type == REQ_CMD);
    assign launch      = cmd_byte && (i_cmd.byte_value == CH_NUL);

    assign wr.name_we = accept && (i_cmd.req_type == REQ_NAME);
    assign wr.en_we   = accept && (i_cmd.req_type == REQ_ENABLE);
    assign wr.entry   = i_cmd.entry_index;
    assign wr.pos     = i_cmd.char_position;
    assign wr.data    = i_cmd.byte_value;
    assign wr.en      = i_cmd.enable_value;

    tcpm_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (cmd_byte),
        .i_byte     (i_cmd.byte_value),
        .i_clear    (leave),
        .o_parse    (parse)
    );

    assign tok[0].valid = launch;
    assign tok[0].bad   = parse.bad;
    assign tok[0].found = 1'b0;
    assign tok[0].idx   = '0;

    for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
        tcpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(k)),
            .i_wr    (wr),
            .i_parse (parse),
            .i_tok   (tok[k]),
            .i_hold  (hold),
            .o_tok   (tok[k+1])
        );
    end

    assign last  = tok[NUM_ENTRIES];
    assign leave = last.valid && (!r_out_valid || o_res.ready);
    assign hold  = last.valid && !leave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (launch) begin
                r_sweep <= 1'b1;
            end else if (leave) begin
                r_sweep <= 1'b0;
            end
            if (leave) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave) begin
            if (last.bad) begin
                r_status <= ST_BAD;
                r_index  <= '0;
                r_value  <= '0;
            end else begin
                r_status <= last.found ? ST_MATCH : ST_NOMATCH;
                r_index  <= last.found ? CIDX_W'(last.idx) : '0;
                r_value  <= CVAL_W'(parse.value);
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.command_index = r_index;
    assign o_res.command_value = r_value;

endmodule

// File: rtl/tcpm_parser.sv
// Command text parser: identifier buffer, phase tracking and decimal accumulator.
module tcpm_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_vld,
    input  logic [7:0]      i_byte,
    input  logic            i_clear,
    output tcpm_pkg::t_parse o_parse
);
    import tcpm_pkg::*;

    typedef enum logic [1:0] {PH_ID, PH_VALUE, PH_SKIP, PH_BAD} t_phase;

    t_phase                            r_phase;
    logic [MAX_ID_LEN-1:0][BYTE_W-1:0] r_id;
    logic [LEN_W-1:0]                  r_len;
    logic [VALUE_BITS-1:0]             r_value;

    logic is_digit;
    logic is_alnum;

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_alnum = is_digit || ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) ||
                      ((i_byte >= 8'h61) && (i_byte <= 8'h7A));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_ID;
            r_id    <= '0;
            r_len   <= '0;
            r_value <= '0;
        end else if (i_byte_vld && (i_byte != CH_NUL)) begin
            unique case (r_phase) inside
                PH_ID: begin
                    if (i_byte == CH_SPACE) begin
                        r_phase <= PH_VALUE;
                    end else if (!is_alnum || (int'(r_len) >= MAX_ID_LEN)) begin
                        r_phase <= PH_BAD;
                    end else begin
                        r_id[POS_W'(r_len)] <= i_byte;
                        r_len               <= r_len + LEN_W'(1);
                    end
                end
                PH_VALUE: begin
                    if (i_byte == CH_SPACE) begin
                        r_phase <= PH_SKIP;
                    end else if (is_digit) begin
                        // Times ten as two shifts, then add the digit.
                        r_value <= (r_value << 3) + (r_value << 1) +
                                   VALUE_BITS'(i_byte - 8'h30);
                    end else begin
                        r_phase <= PH_BAD;
                    end
                end
                PH_SKIP, PH_BAD: begin
                    r_phase <= r_phase;
                end
                default: begin
                    r_phase <= PH_BAD;
                end
            endcase
        end
    end

    assign o_parse.id    = r_id;
    assign o_parse.len   = r_len;
    assign o_parse.bad   = (r_phase == PH_BAD);
    assign o_parse.value = r_value;

endmodule

// File: rtl/tcpm_cell.sv
// One table entry: stored name and enable, full-name compare, and one stage of the search chain.
module tcpm_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [tcpm_pkg::IDX_W-1:0] i_index,
    input  tcpm_pkg::t_wr           i_wr,
    input  tcpm_pkg::t_parse        i_parse,
    input  tcpm_pkg::t_tok          i_tok,
    input  logic                    i_hold,
    output tcpm_pkg::t_tok          o_tok
);
    import tcpm_pkg::*;

    logic [MAX_ID_LEN-1:0][BYTE_W-1:0] r_name;
    logic                              r_en;
    t_tok                              r_tok;
    t_tok                              n_tok;
    logic                              match;
    logic                              hit;

    assign hit = (int'(i_wr.entry) == int'(i_index));

    // Positions below the identifier length must agree; the position right after
    // it must hold the name terminator unless the identifier fills the store.
    always_comb begin
        match = 1'b1;
        for (int p = 0; p < MAX_ID_LEN; p++) begin
            if (p < int'(i_parse.len)) begin
                match = match & (r_name[p] == i_parse.id[p]);
            end else if (p == int'(i_parse.len)) begin
                match = match & (r_name[p] == CH_NUL);
            end
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.bad && !i_tok.found && r_en && match) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_name <= '0;
            r_en   <= 1'b0;
        end else begin
            if (!i_hold) begin
                r_tok <= n_tok;
            end
            if (i_wr.name_we && hit && (int'(i_wr.pos) < MAX_ID_LEN)) begin
                r_name[POS_W'(i_wr.pos)] <= i_wr.data;
            end
            if (i_wr.en_we && hit) begin
                r_en <= i_wr.en;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/tcpm_checker.sv
// Port-level checks of the command parser and matcher, bound to the top level.
module tcpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_req_type,
    input logic [7:0]  i_byte_value,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [3:0]  i_command_index,
    input logic [31:0] i_command_value
);
    import tcpm_pkg::*;

    // A result word that is not taken stays and keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_command_index) &&
            $stable(i_command_value))
        else $error("result word changed while stalled");

    // A terminating byte starts a search, during which no word is taken.
    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_req_type == REQ_CMD) && (i_byte_value == CH_NUL)
            |=> !i_in_ready)
        else $error("input taken right after a terminating byte");

    // A bad-format result carries neither an index nor a value.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_BAD) |->
            (i_command_index == '0) && (i_command_value == '0))
        else $error("bad-format result with index or value");

    // Only a match reports an index, and the status is always a known code.
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_status == ST_MATCH) || (i_status == ST_BAD) || (i_status == ST_NOMATCH)) &&
            ((i_status == ST_MATCH) || (i_command_index == '0)))
        else $error("unexpected status or index without a match");

endmodule

bind text_command_parse_and_match tcpm_checker u_tcpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cmd.valid),
    .i_in_ready      (i_cmd.ready),
    .i_req_type      (i_cmd.req_type),
    .i_byte_value    (i_cmd.byte_value),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_command_index (o_res.command_index),
    .i_command_value (o_res.command_value)
);
